// ===== src/lbum_pkg.sv =====
package lbum_pkg;

    localparam int PIXEL_W     = 8;
    localparam int FRAME_DIM_W = 11;
    localparam int WINDOW_W    = 5;
    localparam int THRESH_W    = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int Q16_SHIFT   = 16;

    localparam logic [FRAME_DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FRAME_DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [WINDOW_W-1:0]    RST_WINDOW_SIZE  = 5'd9;
    localparam logic [THRESH_W-1:0]    RST_THRESHOLD    = 17'd32768;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_WINDOW_SIZE,
        CFG_THRESHOLD
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               drain;
    } pixel_beat_t;

    typedef struct packed {
        logic mask;
        logic frame_last;
    } mask_beat_t;

endpackage

// ===== src/lbum_ram.sv =====
module lbum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/local_box_uniformity_mask.sv =====
// A result beat passes the pipeline and output queue after the input beat with its window's
// bottom-right pixel is accepted; one input beat is accepted every cycle s_ready is high.
// The line buffer and the column sum memory each take one read and one write per cycle.
// An eight-beat output queue keeps input flowing while results wait to be taken.
// Synchronous active-low reset restores the register defaults and clears all counters;
// line buffer contents stay undefined until written and no clearing pass is run.
module local_box_uniformity_mask #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 31
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lbum_pkg::pixel_beat_t            s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lbum_pkg::mask_beat_t             m_data,
    input  logic                             cfg_wr_en,
    input  logic [lbum_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbum_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    import lbum_pkg::*;

    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int SW       = $clog2(MAX_WINDOW + 1);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT + MAX_WINDOW + 1);
    localparam int CRW      = $clog2(MAX_HEIGHT);
    localparam int LW       = $clog2(MAX_WINDOW);
    localparam int RS_DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int RS_AW    = $clog2(RS_DEPTH);
    localparam int PSQW     = 2 * PIXEL_W;
    localparam int CSW      = $clog2(MAX_WINDOW * 255 + 1);
    localparam int CQW      = $clog2(MAX_WINDOW * 65025 + 1);
    localparam int SUMW     = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int SQW      = $clog2(MAX_WINDOW * MAX_WINDOW * 65025 + 1);
    localparam int AREAW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int TAW      = THRESH_W + AREAW;
    localparam int SSW      = 2 * SUMW;
    localparam int LHSW     = SSW + Q16_SHIFT;
    localparam int RHSW     = TAW + SQW;
    localparam int CMPW     = (LHSW > RHSW) ? LHSW : RHSW;
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    logic [FRAME_DIM_W-1:0] frame_width_reg;
    logic [FRAME_DIM_W-1:0] frame_height_reg;
    logic [WINDOW_W-1:0]    window_size_reg;
    logic [THRESH_W-1:0]    threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            window_size_reg  <= RST_WINDOW_SIZE;
            threshold_reg    <= RST_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wr_data[FRAME_DIM_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wr_data[FRAME_DIM_W-1:0];
                end
                CFG_WINDOW_SIZE: begin
                    window_size_reg <= cfg_wr_data[WINDOW_W-1:0];
                end
                CFG_THRESHOLD: begin
                    threshold_reg <= cfg_wr_data[THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic [WW-1:0] w_eff;
    logic [HW-1:0] hgt_eff;
    logic [SW-1:0] s_eff;
    logic [SW-1:0] h_eff;
    logic [SW-1:0] g_eff;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            hgt_eff = HW'(1);
        end else if (int'(frame_height_reg) > MAX_HEIGHT) begin
            hgt_eff = HW'(MAX_HEIGHT);
        end else begin
            hgt_eff = HW'(frame_height_reg);
        end
        if (window_size_reg == '0) begin
            s_eff = SW'(1);
        end else if (int'(window_size_reg) > MAX_WINDOW) begin
            s_eff = SW'(MAX_WINDOW);
        end else begin
            s_eff = SW'(window_size_reg);
        end
        h_eff = (s_eff - SW'(1)) >> 1;
        g_eff = s_eff >> 1;
    end

    logic [AREAW-1:0] area_reg;
    logic [TAW-1:0]   thr_area_reg;

    always_ff @(posedge aclk) begin
        area_reg     <= AREAW'(s_eff) * AREAW'(s_eff);
        thr_area_reg <= TAW'(threshold_reg) * TAW'(area_reg);
    end

    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [LW-1:0]    slot_reg;
    logic [SW-1:0]    ext_reg;
    logic [CW-1:0]    ccol_reg;
    logic [CRW-1:0]   crow_reg;
    logic [OQ_CW-1:0] pending_reg;
    logic [OQ_CW-1:0] pending_next;

    logic             in_acc;
    logic             row_in_frame;
    logic             counted;
    logic             wr;
    logic             emit;
    logic             center_ok;
    logic             last;
    logic             col_wrap;
    logic             ccol_wrap;
    logic [RS_AW-1:0] rs_addr;
    logic             pop;

    assign s_ready = pending_reg < OQ_CW'(OQ_DEPTH);
    assign in_acc  = s_valid && s_ready;

    always_comb begin
        row_in_frame = 32'(row_reg) < 32'(hgt_eff);
        counted      = in_acc && !(row_in_frame && s_data.drain);
        wr           = counted && row_in_frame;
        emit         = counted && (32'(row_reg) >= 32'(g_eff)) && (ext_reg == g_eff);
        center_ok    = (32'(crow_reg) >= 32'(h_eff))
                    && (32'(crow_reg) + 32'(g_eff) < 32'(hgt_eff))
                    && (32'(ccol_reg) >= 32'(h_eff))
                    && (32'(ccol_reg) + 32'(g_eff) < 32'(w_eff));
        last         = emit && (32'(crow_reg) + 1 == 32'(hgt_eff))
                    && (32'(ccol_reg) + 1 == 32'(w_eff));
        col_wrap     = 32'(col_reg) + 1 >= 32'(w_eff);
        ccol_wrap    = 32'(ccol_reg) + 1 >= 32'(w_eff);
        rs_addr      = RS_AW'(slot_reg) * RS_AW'(MAX_WIDTH) + RS_AW'(col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            ext_reg  <= '0;
            ccol_reg <= '0;
            crow_reg <= '0;
        end else if (counted) begin
            if (last) begin
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
                ext_reg  <= '0;
                ccol_reg <= '0;
                crow_reg <= '0;
            end else begin
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                    if (32'(slot_reg) + 1 >= 32'(s_eff)) begin
                        slot_reg <= '0;
                    end else begin
                        slot_reg <= slot_reg + LW'(1);
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
                if ((32'(row_reg) >= 32'(g_eff)) && (ext_reg != g_eff)) begin
                    ext_reg <= ext_reg + SW'(1);
                end
                if (emit) begin
                    if (ccol_wrap) begin
                        ccol_reg <= '0;
                        crow_reg <= crow_reg + CRW'(1);
                    end else begin
                        ccol_reg <= ccol_reg + CW'(1);
                    end
                end
            end
        end
    end

    // Stage 1: line buffer and column sums arrive from memory.
    logic             s1_wr_reg;
    logic             s1_emit_reg;
    logic             s1_ok_reg;
    logic             s1_last_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic [PSQW-1:0]  s1_psq_reg;
    logic             s1_first_row_reg;
    logic             s1_sub_reg;
    logic             s1_col0_reg;
    logic             s1_colge_reg;
    logic [RS_AW-1:0] s1_addr_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_fwd_px_reg;
    logic             s1_fwd_cs_reg;

    logic             s2_wr_reg;
    logic             s2_emit_reg;
    logic             s2_ok_reg;
    logic             s2_last_reg;
    logic [PIXEL_W-1:0] s2_pix_reg;
    logic [CSW-1:0]   s2_cs_reg;
    logic [CQW-1:0]   s2_cq_reg;
    logic             s2_col0_reg;
    logic             s2_colge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_wr_reg   <= 1'b0;
            s1_emit_reg <= 1'b0;
        end else begin
            s1_wr_reg   <= wr;
            s1_emit_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        s1_ok_reg        <= center_ok;
        s1_last_reg      <= last;
        s1_pix_reg       <= s_data.pixel;
        s1_psq_reg       <= PSQW'(s_data.pixel) * PSQW'(s_data.pixel);
        s1_first_row_reg <= row_reg == '0;
        s1_sub_reg       <= 32'(row_reg) >= 32'(s_eff);
        s1_col0_reg      <= col_reg == '0;
        s1_colge_reg     <= 32'(col_reg) >= 32'(s_eff);
        s1_addr_reg      <= rs_addr;
        s1_col_reg       <= col_reg;
        s1_fwd_px_reg    <= s1_wr_reg && (s1_addr_reg == rs_addr);
        s1_fwd_cs_reg    <= s1_wr_reg && (s1_col_reg == col_reg);
    end

    logic [PIXEL_W-1:0]   rs_rdata;
    logic [CSW+CQW-1:0]   cs_rdata;
    logic [PIXEL_W-1:0]   old_pix;
    logic [PSQW-1:0]      old_psq;
    logic [CSW-1:0]       old_cs;
    logic [CQW-1:0]       old_cq;
    logic [CSW-1:0]       cs_next;
    logic [CQW-1:0]       cq_next;

    lbum_ram #(
        .WIDTH(PIXEL_W),
        .DEPTH(RS_DEPTH)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (s1_wr_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (wr),
        .rd_addr (rs_addr),
        .rd_data (rs_rdata)
    );

    lbum_ram #(
        .WIDTH(CSW + CQW),
        .DEPTH(MAX_WIDTH)
    ) u_col_sums (
        .aclk    (aclk),
        .wr_en   (s1_wr_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({cq_next, cs_next}),
        .rd_en   (wr),
        .rd_addr (col_reg),
        .rd_data (cs_rdata)
    );

    // A beat that reads the entry written by the beat just ahead takes that beat's data.
    always_comb begin
        old_pix = s1_fwd_px_reg ? s2_pix_reg : rs_rdata;
        if (s1_fwd_cs_reg) begin
            old_cs = s2_cs_reg;
            old_cq = s2_cq_reg;
        end else begin
            old_cs = cs_rdata[CSW-1:0];
            old_cq = cs_rdata[CSW+CQW-1:CSW];
        end
        old_psq = PSQW'(old_pix) * PSQW'(old_pix);
        cs_next = (s1_first_row_reg ? '0 : old_cs) + CSW'(s1_pix_reg)
                - (s1_sub_reg ? CSW'(old_pix) : '0);
        cq_next = (s1_first_row_reg ? '0 : old_cq) + CQW'(s1_psq_reg)
                - (s1_sub_reg ? CQW'(old_psq) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_wr_reg   <= 1'b0;
            s2_emit_reg <= 1'b0;
        end else begin
            s2_wr_reg   <= s1_wr_reg;
            s2_emit_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_ok_reg    <= s1_ok_reg;
        s2_last_reg  <= s1_last_reg;
        s2_pix_reg   <= s1_pix_reg;
        s2_cs_reg    <= cs_next;
        s2_cq_reg    <= cq_next;
        s2_col0_reg  <= s1_col0_reg;
        s2_colge_reg <= s1_colge_reg;
    end

    // Stage 2: horizontal running sums over the last s column sums of the row.
    logic [CSW-1:0]  hist_cs_reg [MAX_WINDOW];
    logic [CQW-1:0]  hist_cq_reg [MAX_WINDOW];
    logic [CSW-1:0]  tap_cs;
    logic [CQW-1:0]  tap_cq;
    logic [SUMW-1:0] sum_reg;
    logic [SUMW-1:0] sum_next;
    logic [SQW-1:0]  sq_reg;
    logic [SQW-1:0]  sq_next;

    always_comb begin
        tap_cs   = hist_cs_reg[LW'(s_eff - SW'(1))];
        tap_cq   = hist_cq_reg[LW'(s_eff - SW'(1))];
        sum_next = (s2_col0_reg ? '0 : sum_reg) + SUMW'(s2_cs_reg)
                 - (s2_colge_reg ? SUMW'(tap_cs) : '0);
        sq_next  = (s2_col0_reg ? '0 : sq_reg) + SQW'(s2_cq_reg)
                 - (s2_colge_reg ? SQW'(tap_cq) : '0);
    end

    always_ff @(posedge aclk) begin
        if (s2_wr_reg) begin
            sum_reg        <= sum_next;
            sq_reg         <= sq_next;
            hist_cs_reg[0] <= s2_cs_reg;
            hist_cq_reg[0] <= s2_cq_reg;
            for (int i = 1; i < MAX_WINDOW; i++) begin
                hist_cs_reg[i] <= hist_cs_reg[i-1];
                hist_cq_reg[i] <= hist_cq_reg[i-1];
            end
        end
    end

    logic s3_emit_reg;
    logic s3_ok_reg;
    logic s3_last_reg;

    logic            s4_emit_reg;
    logic            s4_ok_reg;
    logic            s4_last_reg;
    logic [SSW-1:0]  s4_ss_reg;
    logic [RHSW-1:0] s4_rhs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_emit_reg <= 1'b0;
            s4_emit_reg <= 1'b0;
        end else begin
            s3_emit_reg <= s2_emit_reg;
            s4_emit_reg <= s3_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s3_ok_reg   <= s2_ok_reg;
        s3_last_reg <= s2_last_reg;
        s4_ok_reg   <= s3_ok_reg;
        s4_last_reg <= s3_last_reg;
        s4_ss_reg   <= SSW'(sum_reg) * SSW'(sum_reg);
        s4_rhs_reg  <= RHSW'(thr_area_reg) * RHSW'(sq_reg);
    end

    // Stage 4: compare and queue the result.
    mask_beat_t      res_beat;
    logic [CMPW-1:0] lhs_ext;
    logic [CMPW-1:0] rhs_ext;

    always_comb begin
        lhs_ext             = CMPW'(s4_ss_reg) << Q16_SHIFT;
        rhs_ext             = CMPW'(s4_rhs_reg);
        res_beat.mask       = s4_ok_reg && (lhs_ext < rhs_ext);
        res_beat.frame_last = s4_last_reg;
    end

    mask_beat_t       oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_ptr_reg;
    logic [OQ_AW-1:0] oq_rd_ptr_reg;
    logic [OQ_CW-1:0] oq_count_reg;
    logic [OQ_CW-1:0] oq_count_next;

    assign m_valid       = oq_count_reg != '0;
    assign m_data        = oq_mem_reg[oq_rd_ptr_reg];
    assign pop           = m_valid && m_ready;
    assign oq_count_next = oq_count_reg + OQ_CW'(s4_emit_reg) - OQ_CW'(pop);
    assign pending_next  = pending_reg + OQ_CW'(emit) - OQ_CW'(pop);

    always_ff @(posedge aclk) begin
        if (s4_emit_reg) begin
            oq_mem_reg[oq_wr_ptr_reg] <= res_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
            pending_reg   <= '0;
        end else begin
            if (s4_emit_reg) begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + OQ_AW'(1);
            end
            if (pop) begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + OQ_AW'(1);
            end
            oq_count_reg <= oq_count_next;
            pending_reg  <= pending_next;
        end
    end

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= OQ_CW'(OQ_DEPTH))
        else $error("More result beats in flight than the output queue holds.");

    a_queue_covered: assert property (@(posedge aclk) disable iff (!aresetn)
        oq_count_reg <= pending_reg)
        else $error("Output queue holds beats that were never counted in flight.");

    a_forward_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_wr_reg && (s1_fwd_px_reg || s1_fwd_cs_reg)) |-> s2_wr_reg)
        else $error("Forwarded memory data comes from a beat that made no write.");

endmodule
